>>> design/tula_pkg.sv
package tula_pkg;

  localparam int DEF_ENTRIES = 256;
  localparam int UID_W = 17;
  localparam int TITLE_W = 64;
  localparam int UID_BASE = 32'h1000;
  localparam logic [TITLE_W-1:0] SYSTEM_TITLE = 64'h0000_0001_0000_0002;

  typedef struct packed {
    logic [TITLE_W-1:0] title_id;
    logic               auto_create;
  } req_t;

  typedef struct packed {
    logic [UID_W-1:0] user_id;
    logic             found;
    logic             created;
    logic             table_full;
  } rsp_t;

  // lookup travelling down the row of cells
  typedef struct packed {
    logic               valid;
    logic               hit;
    logic               create;
    logic [UID_W-1:0]   uid;
    logic [TITLE_W-1:0] title;
  } probe_t;

endpackage

>>> design/title_uid_lookup_or_assign.sv
// title user-id table: lookup of a 64-bit title id, with optional append
// request channel: req_valid / req_stall carry one item (title_id, auto_create)
// response channel: rsp_valid / rsp_stall carry one item (user_id, found,
//   created, table_full); user_id is 0x1000 plus the entry index, 0 when none
// the table is a row of ENTRIES cells, one title per cell; a lookup enters
//   the first cell and moves one cell per cycle, each filled cell comparing
//   its title, so the row length sets the scan time
// a lookup passes the head register, each cell's register and the response register
//   before rsp_valid; the block takes no new item until the last one is through,
//   one lookup in flight at a time; req_stall is high while it is in the row
// a miss with auto_create set writes the title into the cell at the fill
//   count as the lookup leaves the row; a full table refuses and flags it
// reset: synchronous, active high; the table then holds one entry, the
//   system title with user id 0x1000, and both channels are empty
// when the receiver stalls, the finished response waits in a holding
//   register and the block takes no new item until it has been handed on
module title_uid_lookup_or_assign #(
  parameter int ENTRIES = tula_pkg::DEF_ENTRIES
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  tula_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output tula_pkg::rsp_t rsp
);
  import tula_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t state, state_next;

  // probe[i] feeds cell i; probe[ENTRIES] leaves the last cell
  probe_t probe [0:ENTRIES];

  logic [CW-1:0] count;
  logic          req_take;
  logic          rsp_take;
  logic          scan_done;
  logic          room;
  logic          wr_en;
  rsp_t          result;
  rsp_t          pend;
  logic          rsp_free;

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_take  = rsp_valid && !rsp_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // head of the row
  always_ff @(posedge clk) begin
    if (rst) begin
      probe[0].valid <= 1'b0;
    end else begin
      probe[0].valid <= req_take;
    end
    if (req_take) begin
      probe[0].title  <= req.title_id;
      probe[0].create <= req.auto_create;
    end
    probe[0].hit <= 1'b0;
    probe[0].uid <= '0;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    tula_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .probe_in  (probe[i]),
      .probe_out (probe[i+1]),
      .count     (count),
      .wr_en     (wr_en),
      .wr_title  (probe[ENTRIES].title)
    );
  end

  // outcome once the lookup has passed every cell
  assign scan_done = probe[ENTRIES].valid;
  assign room      = count < CW'(ENTRIES);
  assign wr_en     = scan_done && !probe[ENTRIES].hit && probe[ENTRIES].create && room;

  always_comb begin
    result = '0;
    if (probe[ENTRIES].hit) begin
      result.user_id = probe[ENTRIES].uid;
      result.found   = 1'b1;
    end else if (probe[ENTRIES].create) begin
      if (room) begin
        result.user_id = UID_W'(32'(UID_BASE) + 32'(count));
        result.created = 1'b1;
      end else begin
        result.table_full = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CW'(1);
    end else if (wr_en) begin
      count <= count + CW'(1);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_take) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = rsp_free ? S_IDLE : S_HOLD;
        end
      end
      S_HOLD: begin
        if (!rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // response register and holding register behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (scan_done && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if ((state == S_HOLD) && !rsp_stall) begin
      rsp_valid <= 1'b1;
    end else if (rsp_take) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_done && rsp_free) begin
      rsp <= result;
    end else if ((state == S_HOLD) && !rsp_stall) begin
      rsp <= pend;
    end
    if (scan_done && !rsp_free) begin
      pend <= result;
    end
  end

  // no lookup may leave the row while new items are taken
  a_idle_row_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !scan_done)
    else $error("lookup left the row while idle");

  // fill count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRIES))
    else $error("fill count beyond table size");

  // every append bumps the fill count by one
  a_append_count: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (count == $past(count) + CW'(1)))
    else $error("append did not advance fill count");

  // while a finished response is held back, the earlier one is still presented
  a_hold_has_rsp: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD) |-> rsp_valid)
    else $error("holding a response with none presented");

endmodule

>>> design/tula_cell.sv
module tula_cell #(
  parameter int INDEX = 0,
  parameter int CW = 9
) (
  input  logic            clk,
  input  logic            rst,
  input  tula_pkg::probe_t probe_in,
  output tula_pkg::probe_t probe_out,
  input  logic [CW-1:0]   count,
  input  logic            wr_en,
  input  logic [63:0]     wr_title
);
  import tula_pkg::*;

  localparam logic [UID_W-1:0] MY_UID = UID_W'(UID_BASE + INDEX);

  logic [TITLE_W-1:0] entry;
  logic               filled;
  logic               match;

  // entries at or beyond the fill count are never compared
  assign filled = CW'(INDEX) < count;
  assign match  = probe_in.valid && !probe_in.hit && filled && (entry == probe_in.title);

  always_ff @(posedge clk) begin
    if (rst && (INDEX == 0)) begin
      entry <= SYSTEM_TITLE;
    end else if (wr_en && (count == CW'(INDEX))) begin
      entry <= wr_title;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_in.valid;
    end
    probe_out.title  <= probe_in.title;
    probe_out.create <= probe_in.create;
    probe_out.hit    <= probe_in.hit | match;
    probe_out.uid    <= match ? MY_UID : probe_in.uid;
  end

endmodule

>>> tb/tb_title_uid_lookup_or_assign.sv
`timescale 1ns / 1ps

module tb_title_uid_lookup_or_assign;
  import tula_pkg::*;

  localparam int ENTRIES = DEF_ENTRIES;
  localparam int RANDOM_ITEMS = 1530;
  // the receiver freezes once, after this many results, for this many cycles
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 2000;
  // one lookup walks the whole row, so allow a full scan plus margin at the end
  localparam int DRAIN_CYCLES = ENTRIES + 16;

  typedef struct {
    req_t r;
    bit   wait_idle;  // hold this item back until nothing is outstanding
  } queued_req_t;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  title_uid_lookup_or_assign #(
    .ENTRIES(ENTRIES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------
  // predictor: own copy of the title table
  // ---------------------------------------------------------------------
  logic [TITLE_W-1:0] title_table [ENTRIES];
  int unsigned fill_count;

  // scans filled entries in order; first match wins, else append if asked and room remains
  function automatic rsp_t assign_user_id(req_t r);
    rsp_t o;
    int   i;
    o = '0;
    for (i = 0; i < fill_count; i++) begin
      if (title_table[i] == r.title_id) begin
        o.user_id = UID_W'(UID_BASE + i);
        o.found = 1'b1;
        return o;
      end
    end
    // plain miss: everything stays zero
    if (!r.auto_create) return o;
    // no room left: nothing is written, only the flag
    if (fill_count >= ENTRIES) begin
      o.table_full = 1'b1;
      return o;
    end
    title_table[fill_count] = r.title_id;
    o.user_id = UID_W'(UID_BASE + fill_count);
    o.created = 1'b1;
    fill_count++;
    return o;
  endfunction

  initial begin
    title_table[0] = SYSTEM_TITLE;
    fill_count = 1;
  end

  // ---------------------------------------------------------------------
  // stimulus store
  // ---------------------------------------------------------------------
  queued_req_t request_q[$];
  rsp_t uid_due_q[$];
  // titles sent with auto_create, in order; a random repeat is taken back out
  logic [TITLE_W-1:0] known_titles[$];

  int n_err = 0;
  int n_taken = 0;
  int n_given = 0;
  int hold_left = 0;
  queued_req_t next_req;
  rsp_t due;

  task automatic add_item(logic [TITLE_W-1:0] t, bit c, bit w);
    queued_req_t q;
    q.r.title_id = t;
    q.r.auto_create = c;
    q.wait_idle = w;
    request_q.push_back(q);
    if (c) known_titles.push_back(t);
  endtask

  // ---------------------------------------------------------------------
  // driver: offers the head of the queue, holds it steady while stalled
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        uid_due_q.push_back(assign_user_id(req));
        n_taken++;
      end
      // payload may only move when the slot is empty or just taken
      if (!req_valid || !req_stall) begin
        if (request_q.size() != 0
            && !(request_q[0].wait_idle && uid_due_q.size() != 0)
            && !((n_taken < 600 || n_taken >= 800) && $urandom_range(99) < 18)) begin
          next_req = request_q.pop_front();
          req <= next_req.r;
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // monitor: checks each result against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (uid_due_q.size() == 0) begin
          $error("result item with nothing expected: user_id %h", rsp.user_id);
          n_err++;
        end else begin
          due = uid_due_q.pop_front();
          if (rsp.user_id !== due.user_id) begin
            $error("user_id: expected %h, got %h", due.user_id, rsp.user_id);
            n_err++;
          end
          if (rsp.found !== due.found) begin
            $error("found: expected %b, got %b", due.found, rsp.found);
            n_err++;
          end
          if (rsp.created !== due.created) begin
            $error("created: expected %b, got %b", due.created, rsp.created);
            n_err++;
          end
          if (rsp.table_full !== due.table_full) begin
            $error("table_full: expected %b, got %b", due.table_full, rsp.table_full);
            n_err++;
          end
        end
        n_given++;
        // long freeze so the block backs up and stalls the sender
        if (n_given == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else begin
        rsp_stall <= (n_given < 900 || n_given >= 1100) && $urandom_range(99) < 18;
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    int pick;
    int idx;
    int n_stored;
    logic [TITLE_W-1:0] t;
    bit c;
    bit w;

    // directed: system title, extremes, near misses, append then hit
    add_item(SYSTEM_TITLE, 1'b0, 1'b0);
    add_item(SYSTEM_TITLE, 1'b1, 1'b0);
    add_item('0, 1'b0, 1'b0);
    add_item('1, 1'b0, 1'b0);
    add_item(SYSTEM_TITLE + 1, 1'b0, 1'b0);
    add_item(SYSTEM_TITLE - 2, 1'b0, 1'b0);
    add_item('0, 1'b1, 1'b0);
    add_item('0, 1'b0, 1'b0);
    add_item('1, 1'b1, 1'b0);
    add_item('1, 1'b0, 1'b0);
    add_item(SYSTEM_TITLE - 1, 1'b1, 1'b0);
    add_item(64'haaaa_aaaa_aaaa_aaaa, 1'b1, 1'b0);
    add_item(64'h5555_5555_5555_5555, 1'b1, 1'b0);
    add_item(64'h8000_0000_0000_0000, 1'b1, 1'b0);
    add_item(64'h0000_0000_0000_0001, 1'b1, 1'b0);
    add_item(64'haaaa_aaaa_aaaa_aaaa, 1'b0, 1'b0);
    add_item(64'h5555_5555_5555_5555, 1'b1, 1'b0);
    add_item(64'h8000_0000_0000_0001, 1'b0, 1'b0);
    add_item(SYSTEM_TITLE, 1'b0, 1'b0);
    add_item(64'h0000_0000_0000_0001, 1'b0, 1'b0);

    // random: hits, near misses, fresh appends and plain misses; the table
    // fills partway through, after which appends come back flagged as full
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      pick = $urandom_range(99);
      c = 1'($urandom_range(1));
      // a few items wait until every earlier result has come back
      w = (k == 0 || k == 700 || k == 1200);
      if (pick < 40) begin
        n_stored = (known_titles.size() < ENTRIES - 1) ? known_titles.size() : ENTRIES - 1;
        idx = $urandom_range(known_titles.size() - 1);
        // now and then aim at the newest stored entry
        if ($urandom_range(7) == 0) idx = n_stored - 1;
        t = known_titles[idx];
        // a repeated title is already stored or was refused; not a new append
        add_item(t, c, w);
        if (c) void'(known_titles.pop_back());
      end else if (pick < 42) begin
        case ($urandom_range(2))
          0: t = '0;
          1: t = '1;
          default: t = SYSTEM_TITLE;
        endcase
        add_item(t, c, w);
        if (c) void'(known_titles.pop_back());
      end else if (pick < 46) begin
        // one bit away from a known title
        t = known_titles[$urandom_range(known_titles.size() - 1)];
        t[$urandom_range(TITLE_W - 1)] ^= 1'b1;
        add_item(t, c, w);
      end else if (pick < 76) begin
        add_item({$urandom, $urandom}, 1'b1, w);
      end else begin
        add_item({$urandom, $urandom}, 1'b0, w);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (request_q.size() != 0 || req_valid) @(posedge clk);
    while (uid_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_err == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // safety net: roughly seven times the slowest expected run
  initial begin
    #30000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
